// ===== src/tmcw_pkg.sv =====
// Package for the text-mode console writer.
// Holds the item structs, operation and register codes and default geometry.
// Used by every module of the block; depends on nothing.
package tmcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;

  // APB register indexes
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_CLEAR = 3'b100
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  char_byte;
    logic [10:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cell_index;
    logic [15:0] cell_value;
    logic        cell_written;
    logic [10:0] cursor_offset;
  } out_item_t;

endpackage

// ===== src/tmcw_regs.sv =====
// APB register file of the console writer: foreground and background color.
// Depends on tmcw_pkg; feeds the current attribute byte to the top level.
module tmcw_regs import tmcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [7:0]        attr_o
);

  logic [3:0] fg_q, fg_d;
  logic [3:0] bg_q, bg_d;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_FG:  fg_d = pwdata[3:0];
        REG_BG:  bg_d = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd14;
      bg_q <= 4'd2;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FG:  prdata = {{(APB_DW-4){1'b0}}, fg_q};
      REG_BG:  prdata = {{(APB_DW-4){1'b0}}, bg_q};
      default: prdata = '0;
    endcase
  end

  assign attr_o = {bg_q, fg_q};

endmodule

// ===== src/tmcw_screen_mem.sv =====
// Screen cell store: one write port, one read port with registered data.
// Depends on tmcw_pkg for its default depth, ROWS_DEF * COLUMNS_DEF.
module tmcw_screen_mem import tmcw_pkg::*; #(
  parameter int DEPTH = ROWS_DEF * COLUMNS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/text_mode_console_writer_unit.sv =====
// Text-mode console writer: a ROWS x COLUMNS store of 16-bit cells and a cursor.
// A put or an unused op is answered from the idle state; a read passes through the read
// state while the cell store's registered read data arrives, and a clear sweeps one cell per
// cycle through the store's single write port before it answers. The next item is taken only
// in the idle state, when the output register is empty or its result leaves that cycle.
// Depends on tmcw_pkg, tmcw_regs and tmcw_screen_mem.
module text_mode_console_writer_unit import tmcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [7:0]    attr;
  state_e        state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [15:0]   fill_q, fill_d;
  logic          rd_ok_q, rd_ok_d;
  logic [10:0]   rd_idx_q, rd_idx_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          accept;
  logic          is_newline;
  logic [AW-1:0] cur;
  logic [AW-1:0] cur_next;
  logic [AW+10:0] cur_ext;
  logic [AW+10:0] cur_next_ext;
  logic [AW+10:0] rd_ext;
  logic          rd_in_range;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   mem_rdata;

  tmcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  tmcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ext[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign is_newline  = (in_item_i.char_byte == NEWLINE_BYTE);

  assign cur          = base_q + AW'(col_q);
  assign cur_next     = base_d + AW'(col_d);
  assign cur_ext      = {{11{1'b0}}, cur};
  assign cur_next_ext = {{11{1'b0}}, cur_next};
  assign rd_ext       = {{AW{1'b0}}, in_item_i.read_index};
  assign rd_in_range  = ({21'b0, in_item_i.read_index} < 32'(CELLS));

  assign mem_re = accept && (in_item_i.op == OP_READ) && rd_in_range;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = {attr, in_item_i.char_byte};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = fill_q;
    end else if (accept && (in_item_i.op == OP_PUT) && !is_newline) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    clr_addr_d  = clr_addr_q;
    fill_d      = fill_q;
    rd_ok_d     = rd_ok_q;
    rd_idx_d    = rd_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.op)
            OP_PUT: begin
              // advance the cursor; a newline or the row end wraps to the next row, after the last row to the first
              if (is_newline || (col_q == CW'(COLUMNS - 1))) begin
                col_d = '0;
                if (row_q == RW'(ROWS - 1)) begin
                  row_d  = '0;
                  base_d = '0;
                end else begin
                  row_d  = row_q + 1'b1;
                  base_d = base_q + AW'(COLUMNS);
                end
              end else begin
                col_d = col_q + 1'b1;
              end
              out_d.cell_index    = is_newline ? 11'd0 : cur_ext[10:0];
              out_d.cell_value    = is_newline ? 16'd0 : {attr, in_item_i.char_byte};
              out_d.cell_written  = !is_newline;
              out_d.cursor_offset = cur_next_ext[10:0];
              out_valid_d         = 1'b1;
            end
            OP_CLEAR: begin
              fill_d     = {attr, SPACE_BYTE};
              clr_addr_d = '0;
              row_d      = '0;
              col_d      = '0;
              base_d     = '0;
              state_d    = ST_CLEAR;
            end
            OP_READ: begin
              rd_ok_d  = rd_in_range;
              rd_idx_d = in_item_i.read_index;
              state_d  = ST_READ;
            end
            default: begin
              out_d.cell_index    = '0;
              out_d.cell_value    = '0;
              out_d.cell_written  = 1'b0;
              out_d.cursor_offset = cur_ext[10:0];
              out_valid_d         = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_d.cell_index    = rd_idx_q;
        out_d.cell_value    = rd_ok_q ? mem_rdata : 16'd0;
        out_d.cell_written  = 1'b0;
        out_d.cursor_offset = cur_ext[10:0];
        out_valid_d         = 1'b1;
        state_d             = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(CELLS - 1)) begin
          out_d.cell_index    = '0;
          out_d.cell_value    = fill_q;
          out_d.cell_written  = 1'b0;
          out_d.cursor_offset = '0;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q   <= fill_d;
    rd_ok_q  <= rd_ok_d;
    rd_idx_q <= rd_idx_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
